### rtl/esc_pkg.sv
// Shared types and constants of the environmental sensor compensation unit.
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

  // Widths of the configuration write channel
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 56;

  // Widths of the measurement and result fields
  localparam int unsigned RawTempW  = 20;
  localparam int unsigned RawPresW  = 20;
  localparam int unsigned RawHumW   = 16;
  localparam int unsigned TempOutW  = 16;
  localparam int unsigned PresOutW  = 24;
  localparam int unsigned HumOutW   = 17;

  // Calibration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_CAL  = 3'd0,
    REG_PRES_CAL_A = 3'd1,
    REG_PRES_CAL_B = 3'd2,
    REG_PRES_CAL_C = 3'd3,
    REG_HUM_CAL_A  = 3'd4,
    REG_HUM_CAL_B  = 3'd5
  } esc_reg_e;

  // Calibration words, each extended to the 32-bit working width
  typedef struct packed {
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] t3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [31:0] p3;
    logic signed [31:0] p4;
    logic signed [31:0] p5;
    logic signed [31:0] p6;
    logic signed [31:0] p7;
    logic signed [31:0] p8;
    logic signed [31:0] p9;
    logic signed [31:0] p10;
    logic signed [31:0] h1;
    logic signed [31:0] h2;
    logic signed [31:0] h3;
    logic signed [31:0] h4;
    logic signed [31:0] h5;
    logic signed [31:0] h6;
    logic signed [31:0] h7;
  } cal_t;

endpackage

`default_nettype wire

### rtl/esc_if.sv
// Valid/ready channel interfaces: measurements, results and calibration writes.
`timescale 1ns / 1ps
`default_nettype none

interface esc_in_if;
  logic                             valid;
  logic                             ready;
  logic [esc_pkg::RawTempW-1:0]     raw_temperature;
  logic [esc_pkg::RawPresW-1:0]     raw_pressure;
  logic [esc_pkg::RawHumW-1:0]      raw_humidity;

  modport source (output valid, raw_temperature, raw_pressure, raw_humidity,
                  input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, raw_humidity,
                  output ready);
endinterface

interface esc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [esc_pkg::TempOutW-1:0] temperature_centi;
  logic [esc_pkg::PresOutW-1:0]       pressure_pascal;
  logic [esc_pkg::HumOutW-1:0]        humidity_milli;
  logic                               divide_fault;

  modport source (output valid, temperature_centi, pressure_pascal, humidity_milli,
                  divide_fault, input ready);
  modport sink   (input valid, temperature_centi, pressure_pascal, humidity_milli,
                  divide_fault, output ready);
endinterface

interface esc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [esc_pkg::CfgIdxW-1:0]  index;
  logic [esc_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/esc_cfg_regs.sv
// Calibration registers and unpacking of the calibration words.
`timescale 1ns / 1ps
`default_nettype none

module esc_cfg_regs (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  esc_cfg_if.sink    cfg_i,
  output esc_pkg::cal_t cal_o
);

  logic [39:0] temp_q;
  logic [55:0] pres_a_q;
  logic [47:0] pres_b_q;
  logic [23:0] pres_c_q;
  logic [47:0] hum_a_q;
  logic [15:0] hum_b_q;

  // Writes always complete; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q   <= '0;
      pres_a_q <= '0;
      pres_b_q <= '0;
      pres_c_q <= '0;
      hum_a_q  <= '0;
      hum_b_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        esc_pkg::REG_TEMP_CAL:   temp_q   <= cfg_i.data[39:0];
        esc_pkg::REG_PRES_CAL_A: pres_a_q <= cfg_i.data[55:0];
        esc_pkg::REG_PRES_CAL_B: pres_b_q <= cfg_i.data[47:0];
        esc_pkg::REG_PRES_CAL_C: pres_c_q <= cfg_i.data[23:0];
        esc_pkg::REG_HUM_CAL_A:  hum_a_q  <= cfg_i.data[47:0];
        esc_pkg::REG_HUM_CAL_B:  hum_b_q  <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Field unpacking: unsigned words zero-extend, signed words sign-extend
  always_comb begin
    cal_o.t1  = {16'd0, temp_q[15:0]};
    cal_o.t2  = {{16{temp_q[31]}}, temp_q[31:16]};
    cal_o.t3  = {{24{temp_q[39]}}, temp_q[39:32]};
    cal_o.p1  = {16'd0, pres_a_q[15:0]};
    cal_o.p2  = {{16{pres_a_q[31]}}, pres_a_q[31:16]};
    cal_o.p3  = {{24{pres_a_q[39]}}, pres_a_q[39:32]};
    cal_o.p4  = {{16{pres_a_q[55]}}, pres_a_q[55:40]};
    cal_o.p5  = {{16{pres_b_q[15]}}, pres_b_q[15:0]};
    cal_o.p6  = {{24{pres_b_q[23]}}, pres_b_q[23:16]};
    cal_o.p7  = {{24{pres_b_q[31]}}, pres_b_q[31:24]};
    cal_o.p8  = {{16{pres_b_q[47]}}, pres_b_q[47:32]};
    cal_o.p9  = {{16{pres_c_q[15]}}, pres_c_q[15:0]};
    cal_o.p10 = {24'd0, pres_c_q[23:16]};
    cal_o.h1  = {20'd0, hum_a_q[11:0]};
    cal_o.h2  = {20'd0, hum_a_q[23:12]};
    cal_o.h3  = {{24{hum_a_q[31]}}, hum_a_q[31:24]};
    cal_o.h4  = {{24{hum_a_q[39]}}, hum_a_q[39:32]};
    cal_o.h5  = {{24{hum_a_q[47]}}, hum_a_q[47:40]};
    cal_o.h6  = {24'd0, hum_b_q[7:0]};
    cal_o.h7  = {{24{hum_b_q[15]}}, hum_b_q[15:8]};
  end

endmodule

`default_nettype wire

### rtl/environmental_sensor_compensation_unit.sv
// Top level: pipelined integer compensation of temperature, pressure, humidity.
//
// Usage:
//   cfg_i  - calibration writes (index, data), always ready; write only while
//            the pipeline holds no item.
//   in_i   - one raw measurement (temperature, pressure, humidity) per transfer.
//   out_o  - one compensated result per measurement, in order.
// Throughput: one measurement per cycle while the receiver takes results. The
//   pipeline depth is set by the pressure divide, a restoring divider that
//   settles one quotient bit per stage (32 stages), plus the multiply stages
//   before and after it.
// Stall: each stage moves when the next one is empty or moving, so a stalled
//   receiver fills bubbles first; input ready drops only once the whole
//   pipeline is full. No item is dropped or repeated.
// Reset: all stage valid bits and calibration registers clear; the first
//   input can be taken in the cycle after reset is released.
// A zero pressure divisor forces pressure to 0 and sets divide_fault.
`timescale 1ns / 1ps
`default_nettype none

module environmental_sensor_compensation_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  esc_cfg_if.sink   cfg_i,
  esc_in_if.sink    in_i,
  esc_out_if.source out_o
);

  localparam int unsigned NumStages = 49;
  localparam int unsigned DivFirst  = 12;
  localparam int unsigned DivLast   = 43;
  localparam logic [63:0] Recip100  = 64'd2748779070;  // ceil(2^38 / 100)

  typedef struct {
    logic signed [31:0] padc;
    logic signed [31:0] hadc;
    logic signed [31:0] ta;
    logic signed [31:0] m1;
    logic signed [31:0] m2;
    logic signed [31:0] tb;
    logic signed [31:0] m3;
    logic signed [31:0] tf;
    logic signed [31:0] ts;
    logic signed [15:0] tout;
    logic signed [31:0] pa;
    logic signed [31:0] psq;
    logic signed [31:0] m5;
    logic signed [31:0] m6;
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic signed [31:0] pb;
    logic signed [31:0] pa2;
    logic signed [31:0] am;
    logic signed [31:0] pcd;
    logic signed [31:0] pcm;
    logic signed [31:0] adiv;
    logic        [31:0] num;
    logic        [31:0] den;
    logic        [31:0] rem;
    logic               big;
    logic               qneg;
    logic               fault;
    logic signed [31:0] pc;
    logic signed [31:0] sqa;
    logic signed [31:0] m8;
    logic signed [31:0] cube1;
    logic signed [31:0] ap9;
    logic signed [31:0] cube2;
    logic signed [31:0] b8;
    logic signed [31:0] pa9;
    logic signed [31:0] cube3;
    logic signed [31:0] pcf;
    logic        [23:0] pout;
    logic signed [31:0] hm3;
    logic signed [31:0] hm4;
    logic signed [31:0] hm5;
    logic signed [31:0] hm7;
    logic        [32:0] hq3;
    logic        [32:0] hq4;
    logic        [32:0] hq5;
    logic        [32:0] hq7;
    logic signed [31:0] d3;
    logic signed [31:0] d4;
    logic signed [31:0] d5;
    logic signed [31:0] d7;
    logic signed [31:0] hm;
    logic signed [31:0] ha;
    logic signed [31:0] hd;
    logic        [32:0] hq5b;
    logic signed [31:0] d5b;
    logic signed [31:0] hb;
    logic signed [31:0] hc;
    logic signed [31:0] he0;
    logic signed [31:0] hf0;
    logic signed [31:0] hg;
    logic        [16:0] hout;
  } item_t;

  // First half of signed divide by 100: sign and magnitude quotient
  function automatic logic [32:0] div100_mag(input logic signed [31:0] x);
    logic [31:0] u;
    logic [63:0] prod;
    begin
      u    = x[31] ? 32'(-x) : 32'(x);
      prod = {32'd0, u} * Recip100;
      return {x[31], 6'd0, prod[63:38]};
    end
  endfunction

  // Second half: apply the sign, truncating toward zero
  function automatic logic signed [31:0] div100_fin(input logic [32:0] s);
    return s[32] ? -$signed(s[31:0]) : $signed(s[31:0]);
  endfunction

  esc_pkg::cal_t cal;

  esc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cal_o  (cal)
  );

  item_t                   stage_q [NumStages+1];
  item_t                   stage_d [1:NumStages];
  logic [NumStages:0]      valid_q;
  logic [NumStages+1:1]    adv;

  // Stage 0 slot: raw fields enter as non-negative 32-bit values
  always_comb begin
    stage_q[0]      = '{default: '0};
    stage_q[0].padc = $signed({12'd0, in_i.raw_pressure});
    stage_q[0].hadc = $signed({16'd0, in_i.raw_humidity});
    stage_q[0].ta   = $signed({12'd0, in_i.raw_temperature});
  end

  assign valid_q[0]         = in_i.valid;
  assign adv[NumStages + 1] = out_o.ready;
  assign in_i.ready         = adv[1];

  for (genvar k = 1; k <= NumStages; k++) begin : g_stage
    localparam int unsigned K = k;

    assign adv[k] = !valid_q[k] || adv[k+1];

    // Per-stage arithmetic
    always_comb begin
      item_t              p;
      item_t              n;
      logic        [32:0] shifted;
      logic               qbit;
      logic signed [31:0] tmp;
      p       = stage_q[k-1];
      n       = p;
      shifted = '0;
      qbit    = 1'b0;
      tmp     = '0;

      // Restoring divider, one quotient bit per stage
      if (K >= DivFirst && K <= DivLast) begin
        shifted = {p.rem, p.num[31]};
        qbit    = (shifted >= {1'b0, p.den});
        n.rem   = qbit ? 32'(shifted - {1'b0, p.den}) : shifted[31:0];
        n.num   = {p.num[30:0], qbit};
      end

      case (K)
        1: begin
          n.ta = (p.ta >>> 3) - (cal.t1 <<< 1);
        end
        2: begin
          n.m1 = p.ta * cal.t2;
          n.m2 = (p.ta >>> 1) * (p.ta >>> 1);
        end
        3: begin
          n.tb = p.m1 >>> 11;
          n.m3 = (p.m2 >>> 12) * (cal.t3 <<< 4);
        end
        4: begin
          n.tf = p.tb + (p.m3 >>> 14);
        end
        5: begin
          n.ts = ((p.tf <<< 2) + p.tf + 32'sd128) >>> 8;
          n.pa = (p.tf >>> 1) - 32'sd64000;
        end
        6: begin
          if (p.ts > 32'sd32767) n.tout = 16'sh7fff;
          else if (p.ts < -32'sd32768) n.tout = 16'sh8000;
          else n.tout = p.ts[15:0];
          n.psq = (p.pa >>> 2) * (p.pa >>> 2);
          n.m5  = p.pa * cal.p5;
          n.m6  = cal.p2 * p.pa;
          n.hm3 = p.ts * cal.h3;
          n.hm4 = p.ts * cal.h4;
          n.hm5 = p.ts * cal.h5;
          n.hm7 = p.ts * cal.h7;
        end
        7: begin
          n.x1  = (p.psq >>> 11) * cal.p6;
          n.x2  = (p.psq >>> 13) * (cal.p3 <<< 5);
          n.hq3 = div100_mag(p.hm3);
          n.hq4 = div100_mag(p.hm4);
          n.hq5 = div100_mag(p.hm5);
          n.hq7 = div100_mag(p.hm7);
        end
        8: begin
          n.pb  = (((p.x1 >>> 2) + (p.m5 <<< 1)) >>> 2) + (cal.p4 <<< 16);
          n.pa2 = ((p.x2 >>> 3) + (p.m6 >>> 1)) >>> 18;
          n.d3  = div100_fin(p.hq3);
          n.d4  = div100_fin(p.hq4);
          n.d5  = div100_fin(p.hq5);
          n.d7  = div100_fin(p.hq7);
        end
        9: begin
          n.am  = (32'sd32768 + p.pa2) * cal.p1;
          n.pcd = 32'sd1048576 - p.padc - (p.pb >>> 12);
          n.hm  = p.ts * p.d5;
          n.ha  = (p.hadc - (cal.h1 <<< 4)) - (p.d3 >>> 1);
          n.hd  = ((cal.h6 <<< 7) + p.d7) >>> 4;
        end
        10: begin
          n.pcm  = p.pcd * 32'sd3125;
          n.adiv = p.am >>> 15;
          n.hq5b = div100_mag(p.hm >>> 6);
        end
        11: begin
          // Divider setup: large dividends are divided first, doubled after
          n.fault = (p.adiv == 32'sd0);
          n.big   = !p.pcm[31] && (p.pcm >= 32'sh4000_0000);
          tmp     = n.big ? p.pcm : (p.pcm <<< 1);
          n.num   = tmp[31] ? 32'(-tmp) : 32'(tmp);
          n.den   = p.adiv[31] ? 32'(-p.adiv) : 32'(p.adiv);
          n.qneg  = tmp[31] ^ p.adiv[31];
          n.rem   = '0;
          n.d5b   = div100_fin(p.hq5b);
        end
        12: begin
          n.hb = cal.h2 * (p.d4 + p.d5b + 32'sd16384);
        end
        13: begin
          n.hc = p.ha * (p.hb >>> 10);
        end
        14: begin
          n.he0 = (p.hc >>> 14) * (p.hc >>> 14);
        end
        15: begin
          n.hf0 = p.hd * (p.he0 >>> 10);
        end
        16: begin
          n.hg = ((p.hc + (p.hf0 >>> 1)) >>> 10) * 32'sd1000;
        end
        17: begin
          tmp = p.hg >>> 12;
          if (tmp < 32'sd0) n.hout = '0;
          else if (tmp > 32'sd100000) n.hout = 17'd100000;
          else n.hout = tmp[16:0];
        end
        44: begin
          tmp  = p.qneg ? -$signed(p.num) : $signed(p.num);
          n.pc = p.big ? (tmp <<< 1) : tmp;
        end
        45: begin
          n.sqa   = (p.pc >>> 3) * (p.pc >>> 3);
          n.m8    = (p.pc >>> 2) * cal.p8;
          n.cube1 = (p.pc >>> 8) * (p.pc >>> 8);
        end
        46: begin
          n.ap9   = cal.p9 * (p.sqa >>> 13);
          n.cube2 = p.cube1 * (p.pc >>> 8);
          n.b8    = p.m8 >>> 13;
        end
        47: begin
          n.pa9   = p.ap9 >>> 12;
          n.cube3 = p.cube2 * cal.p10;
        end
        48: begin
          n.pcf = p.pc + ((p.pa9 + p.b8 + (p.cube3 >>> 17) + (cal.p7 <<< 7)) >>> 4);
        end
        49: begin
          if (p.fault || p.pcf < 32'sd0) n.pout = '0;
          else if (p.pcf > 32'sd16777215) n.pout = 24'hff_ffff;
          else n.pout = p.pcf[23:0];
        end
        default: ;
      endcase
      stage_d[k] = n;
    end

    // Valid bit travels with the stage data
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv[k]) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  // Result channel
  assign out_o.valid             = valid_q[NumStages];
  assign out_o.temperature_centi = stage_q[NumStages].tout;
  assign out_o.pressure_pascal   = stage_q[NumStages].pout;
  assign out_o.humidity_milli    = stage_q[NumStages].hout;
  assign out_o.divide_fault      = stage_q[NumStages].fault;

endmodule

`default_nettype wire

### rtl/esc_checker.sv
// Port-level checks of the compensation unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module esc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [23:0] pressure_i,
  input wire logic [16:0] humidity_i,
  input wire logic        fault_i
);

  // No result shows while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // Humidity clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> humidity_i <= 17'd100000)
    else $error("humidity above full scale");

  // Divide fault forces zero pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fault_i |-> pressure_i == 24'd0)
    else $error("pressure nonzero on divide fault");

endmodule

bind environmental_sensor_compensation_unit esc_checker u_esc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pressure_i  (out_o.pressure_pascal),
  .humidity_i  (out_o.humidity_milli),
  .fault_i     (out_o.divide_fault)
);

`default_nettype wire

### sim/environmental_sensor_compensation_unit_tb.sv
// Self-checking testbench of the environmental sensor compensation unit.
`timescale 1ns / 1ps

module environmental_sensor_compensation_unit_tb;

  typedef bit [31:0] w32_t;

  typedef struct {
    logic [esc_pkg::RawTempW-1:0] raw_t;
    logic [esc_pkg::RawPresW-1:0] raw_p;
    logic [esc_pkg::RawHumW-1:0]  raw_h;
  } meas_t;

  typedef struct {
    logic signed [esc_pkg::TempOutW-1:0] temp;
    logic [esc_pkg::PresOutW-1:0]        pres;
    logic [esc_pkg::HumOutW-1:0]         hum;
    logic                                fault;
  } comp_t;

  localparam logic [esc_pkg::CfgIdxW-1:0] REG_UNUSED = 3'd6;
  localparam int unsigned IdlePct   = 26;
  localparam int unsigned DrainWait = 60;
  localparam int unsigned HoldLen   = 300;
  localparam int unsigned CycleMax  = 300000;

  logic clk_i;
  logic rst_ni;

  esc_cfg_if cfg_if ();
  esc_in_if  in_if ();
  esc_out_if out_if ();

  environmental_sensor_compensation_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow calibration registers and the work queues
  bit [63:0] cal_shadow [6];
  meas_t     meas_pending [$];
  comp_t     comp_expected [$];
  bit        no_idle;
  int        hold_token;
  int        mismatch_cnt;
  int        cycle_cnt;

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Arithmetic helpers at the 32-bit working width
  function automatic w32_t sra(w32_t a, int s);
    return w32_t'($signed(a) >>> s);
  endfunction

  function automatic w32_t sdiv(w32_t a, w32_t b);
    w32_t ua;
    w32_t ub;
    w32_t q;
    ua = a[31] ? 32'd0 - a : a;
    ub = b[31] ? 32'd0 - b : b;
    q  = ua / ub;
    return (a[31] != b[31]) ? 32'd0 - q : q;
  endfunction

  function automatic w32_t fld(bit [63:0] r, int pos, int bits, bit sgn);
    w32_t m;
    w32_t v;
    m = (w32_t'(1) << bits) - 1;
    if (bits == 32) m = '1;
    v = w32_t'(r >> pos) & m;
    if (sgn && v[bits-1]) v = v | ~m;
    return v;
  endfunction

  function automatic w32_t sat_range(w32_t v, int lo, int hi);
    if ($signed(v) < lo) return w32_t'(lo);
    if ($signed(v) > hi) return w32_t'(hi);
    return v;
  endfunction

  // Compensation of one measurement with the current calibration
  function automatic comp_t compensate(meas_t m);
    comp_t r;
    w32_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
    w32_t h1, h2, h3, h4, h5, h6, h7;
    w32_t a, b, c, d, e, f, tf, ts, pc, tadc, padc, hadc;
    t1  = fld(cal_shadow[0], 0, 16, 0);
    t2  = fld(cal_shadow[0], 16, 16, 1);
    t3  = fld(cal_shadow[0], 32, 8, 1);
    p1  = fld(cal_shadow[1], 0, 16, 0);
    p2  = fld(cal_shadow[1], 16, 16, 1);
    p3  = fld(cal_shadow[1], 32, 8, 1);
    p4  = fld(cal_shadow[1], 40, 16, 1);
    p5  = fld(cal_shadow[2], 0, 16, 1);
    p6  = fld(cal_shadow[2], 16, 8, 1);
    p7  = fld(cal_shadow[2], 24, 8, 1);
    p8  = fld(cal_shadow[2], 32, 16, 1);
    p9  = fld(cal_shadow[3], 0, 16, 1);
    p10 = fld(cal_shadow[3], 16, 8, 0);
    h1  = fld(cal_shadow[4], 0, 12, 0);
    h2  = fld(cal_shadow[4], 12, 12, 0);
    h3  = fld(cal_shadow[4], 24, 8, 1);
    h4  = fld(cal_shadow[4], 32, 8, 1);
    h5  = fld(cal_shadow[4], 40, 8, 1);
    h6  = fld(cal_shadow[5], 0, 8, 0);
    h7  = fld(cal_shadow[5], 8, 8, 1);
    tadc = w32_t'(m.raw_t);
    padc = w32_t'(m.raw_p);
    hadc = w32_t'(m.raw_h);

    // temperature
    a  = (tadc >> 3) - (t1 << 1);
    b  = sra(a * t2, 11);
    c  = sra(sra(a, 1) * sra(a, 1), 12);
    c  = sra(c * (t3 << 4), 14);
    tf = b + c;
    ts = sra(tf * 5 + 128, 8);
    r.temp = sat_range(ts, -32768, 32767);

    // pressure
    a = sra(tf, 1) - 64000;
    b = sra(sra(sra(a, 2) * sra(a, 2), 11) * p6, 2);
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(sra(a, 2) * sra(a, 2), 13) * (p3 << 5), 3) + sra(p2 * a, 1);
    a = sra(a, 18);
    a = sra((32768 + a) * p1, 15);
    pc = 1048576 - padc;
    pc = (pc - sra(b, 12)) * 3125;
    if (a == 0) begin
      r.fault = 1'b1;
      r.pres  = '0;
    end else begin
      r.fault = 1'b0;
      if (!pc[31] && pc >= 32'h4000_0000) pc = sdiv(pc, a) << 1;
      else pc = sdiv(pc << 1, a);
      a  = sra(p9 * sra(sra(pc, 3) * sra(pc, 3), 13), 12);
      b  = sra(sra(pc, 2) * p8, 13);
      c  = sra(sra(pc, 8) * sra(pc, 8) * sra(pc, 8) * p10, 17);
      pc = pc + sra(a + b + c + (p7 << 7), 4);
      r.pres = sat_range(pc, 0, 16777215);
    end

    // humidity, from the unsaturated temperature
    a = (hadc - (h1 << 4)) - sra(sdiv(ts * h3, 100), 1);
    b = sdiv(ts * h4, 100) + sdiv(sra(ts * sdiv(ts * h5, 100), 6), 100) + (1 << 14);
    b = sra(h2 * b, 10);
    c = a * b;
    d = sra((h6 << 7) + sdiv(ts * h7, 100), 4);
    e = sra(sra(c, 14) * sra(c, 14), 10);
    f = sra(d * e, 1);
    r.hum = sat_range(sra(sra(c + f, 10) * 1000, 12), 0, 100000);
    return r;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < IdlePct);
  endfunction

  // Measurement driver: predicts each result at its input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    meas_t m;
    if (!rst_ni) begin
      in_if.valid           <= 1'b0;
      in_if.raw_temperature <= '0;
      in_if.raw_pressure    <= '0;
      in_if.raw_humidity    <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        m.raw_t = in_if.raw_temperature;
        m.raw_p = in_if.raw_pressure;
        m.raw_h = in_if.raw_humidity;
        comp_expected.push_back(compensate(m));
      end
      if (!in_if.valid || in_if.ready) begin
        if (meas_pending.size() > 0 && !idle_now()) begin
          m = meas_pending.pop_front();
          in_if.valid           <= 1'b1;
          in_if.raw_temperature <= m.raw_t;
          in_if.raw_pressure    <= m.raw_p;
          in_if.raw_humidity    <= m.raw_h;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random and long hold-off of ready
  always @(posedge clk_i or negedge rst_ni) begin
    int    hold_left;
    int    hold_seen;
    comp_t x;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (comp_expected.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("Unexpected result transfer at cycle %0d", cycle_cnt);
        end else begin
          x = comp_expected.pop_front();
          if (out_if.temperature_centi !== x.temp || out_if.pressure_pascal !== x.pres ||
              out_if.humidity_milli !== x.hum || out_if.divide_fault !== x.fault) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("Mismatch: exp t=%0d p=%0d h=%0d f=%0b got t=%0d p=%0d h=%0d f=%0b",
                       x.temp, x.pres, x.hum, x.fault, out_if.temperature_centi,
                       out_if.pressure_pascal, out_if.humidity_milli, out_if.divide_fault);
          end
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !idle_now();
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleMax) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Calibration write; the bench issues it only while the pipeline is idle
  task automatic write_cal(logic [esc_pkg::CfgIdxW-1:0] idx, bit [63:0] data);
    bit rdy;
    bit [63:0] mask [6];
    mask = '{64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF,
             64'hFF_FFFF, 64'hFFFF_FFFF_FFFF, 64'hFFFF};
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data[esc_pkg::CfgDataW-1:0];
    do begin
      @(negedge clk_i);
      rdy = cfg_if.ready;
      @(posedge clk_i);
    end while (!rdy);
    cfg_if.valid <= 1'b0;
    if (idx < 6) cal_shadow[idx] = data & mask[idx];
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (meas_pending.size() != 0 || comp_expected.size() != 0 || in_if.valid);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic bit [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // A plausible calibration set, optionally jittered
  task automatic write_typical(bit jitter, bit zero_p1);
    bit [15:0] p1;
    bit [7:0]  jt;
    jt = jitter ? 8'($urandom_range(0, 40)) : 8'd0;
    p1 = zero_p1 ? 16'd0 : 16'd36000 + jt;
    write_cal(esc_pkg::REG_TEMP_CAL,   {8'd3, 16'd26000 + jt, 16'd26300 - jt});
    write_cal(esc_pkg::REG_PRES_CAL_A, {16'd2600, 8'd88, 16'(-10000 + jt), p1});
    write_cal(esc_pkg::REG_PRES_CAL_B, {16'(-2500), 8'd40, 8'd30, 16'(-150 - jt)});
    write_cal(esc_pkg::REG_PRES_CAL_C, {8'd30, 16'(-2000)});
    write_cal(esc_pkg::REG_HUM_CAL_A,  {8'd20, 8'd45, 8'd0, 12'd1000 + jt, 12'd700});
    write_cal(esc_pkg::REG_HUM_CAL_B,  {8'(-100), 8'd120});
  endtask

  task automatic push_meas(int t, int p, int h);
    meas_t m;
    m.raw_t = t;
    m.raw_p = p;
    m.raw_h = h;
    meas_pending.push_back(m);
  endtask

  task automatic push_random(int n, bit typical);
    repeat (n) begin
      if (typical && $urandom_range(99) < 70)
        push_meas($urandom_range(380000, 620000), $urandom_range(250000, 600000),
                  $urandom_range(10000, 40000));
      else
        push_meas($urandom(), $urandom(), $urandom());
    end
  endtask

  task automatic push_directed();
    push_meas(0, 0, 0);
    push_meas(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    push_meas(0, 20'hFFFFF, 0);
    push_meas(20'hFFFFF, 0, 16'hFFFF);
    push_meas(20'h80000, 20'h80000, 16'h8000);
    push_meas(500000, 400000, 25000);
    push_meas(450000, 350000, 5000);
    push_meas(600000, 550000, 45000);
    push_meas(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
  endtask

  // Phases of calibration and stimulus
  initial begin
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    no_idle      = 1'b0;
    hold_token   = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    foreach (cal_shadow[i]) cal_shadow[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset calibration: zero divisor
    push_directed();
    wait_drained();

    // typical set, directed and random, with a long receiver hold-off
    write_typical(0, 0);
    push_directed();
    hold_token++;
    push_random(150, 1);
    wait_drained();

    // all ones
    write_cal(esc_pkg::REG_TEMP_CAL, '1);
    write_cal(esc_pkg::REG_PRES_CAL_A, '1);
    write_cal(esc_pkg::REG_PRES_CAL_B, '1);
    write_cal(esc_pkg::REG_PRES_CAL_C, '1);
    write_cal(esc_pkg::REG_HUM_CAL_A, '1);
    write_cal(esc_pkg::REG_HUM_CAL_B, '1);
    write_cal(REG_UNUSED, rnd64());
    push_directed();
    push_random(100, 0);
    wait_drained();

    // jittered typical set, no idling on either side
    write_typical(1, 0);
    no_idle = 1'b1;
    push_random(150, 1);
    wait_drained();
    no_idle = 1'b0;

    // fully random sets
    repeat (3) begin
      write_cal(esc_pkg::REG_TEMP_CAL, rnd64());
      write_cal(esc_pkg::REG_PRES_CAL_A, rnd64());
      write_cal(esc_pkg::REG_PRES_CAL_B, rnd64());
      write_cal(esc_pkg::REG_PRES_CAL_C, rnd64());
      write_cal(esc_pkg::REG_HUM_CAL_A, rnd64());
      write_cal(esc_pkg::REG_HUM_CAL_B, rnd64());
      push_random(60, 0);
      wait_drained();
    end

    // typical set with zero divisor coefficient
    write_typical(1, 1);
    push_random(60, 1);
    wait_drained();

    // back to a typical set
    write_typical(1, 0);
    hold_token++;
    push_random(120, 1);
    wait_drained();

    if (mismatch_cnt == 0 && comp_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/esc_pkg.sv
rtl/esc_if.sv
rtl/esc_cfg_regs.sv
rtl/environmental_sensor_compensation_unit.sv
rtl/esc_checker.sv
sim/environmental_sensor_compensation_unit_tb.sv
